### hdl/bms_pkg.sv
package bms_pkg;

   // store size and derived widths
   localparam int DEPTH  = 1024;
   localparam int ADDR_W = $clog2(DEPTH);
   localparam int CNT_W  = $clog2(DEPTH + 1);
   localparam int DATA_W = 32;

   localparam logic [CNT_W-1:0] DEPTH_CNT = CNT_W'(DEPTH);

   // request function codes
   localparam logic FUNC_LOAD = 1'b0;
   localparam logic FUNC_READ = 1'b1;

   // input word
   typedef struct packed {
      logic                     func;
      logic signed [DATA_W-1:0] value;
   } req_type;

   // result word
   typedef struct packed {
      logic signed [DATA_W-1:0] sorted_value;
      logic                     is_last;
      logic                     empty_res;
   } rsp_type;

   // controller states
   typedef enum logic [2:0] {
      ST_IDLE,
      ST_PASS,
      ST_SEG,
      ST_MREAD,
      ST_MSTEP,
      ST_FETCH,
      ST_OUT
   } state_type;

   // commands from controller to datapath
   typedef struct packed {
      logic load;
      logic sort_start;
      logic pass_next;
      logic sort_done;
      logic seg_setup;
      logic merge_addr;
      logic merge_write;
      logic deliver;
   } cmd_type;

   // status from datapath to controller
   typedef struct packed {
      logic sorted;
      logic pass_more;
      logic seg_more;
      logic seg_last;
      logic out_free;
   } status_type;

endpackage

### hdl/bms_ctrl.sv
module bms_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   input  logic                   req_func,
   input  bms_pkg::status_type    status,
   output logic                   req_stall,
   output bms_pkg::cmd_type       cmd,
   output bms_pkg::state_type     state
);

   bms_pkg::state_type state_ff;
   bms_pkg::state_type state_in;

   // state register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= bms_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // next state and commands
   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      case (state_ff)
         bms_pkg::ST_IDLE: begin
            if (req_valid) begin
               if (req_func == bms_pkg::FUNC_LOAD) begin
                  cmd.load = 1'b1;
               end else if (status.sorted) begin
                  state_in = bms_pkg::ST_FETCH;
               end else begin
                  cmd.sort_start = 1'b1;
                  state_in       = bms_pkg::ST_PASS;
               end
            end
         end
         bms_pkg::ST_PASS: begin
            if (status.pass_more) begin
               state_in = bms_pkg::ST_SEG;
            end else begin
               cmd.sort_done = 1'b1;
               state_in      = bms_pkg::ST_FETCH;
            end
         end
         bms_pkg::ST_SEG: begin
            if (status.seg_more) begin
               cmd.seg_setup = 1'b1;
               state_in      = bms_pkg::ST_MREAD;
            end else begin
               cmd.pass_next = 1'b1;
               state_in      = bms_pkg::ST_PASS;
            end
         end
         bms_pkg::ST_MREAD: begin
            cmd.merge_addr = 1'b1;
            state_in       = bms_pkg::ST_MSTEP;
         end
         bms_pkg::ST_MSTEP: begin
            cmd.merge_addr  = 1'b1;
            cmd.merge_write = 1'b1;
            state_in = status.seg_last ? bms_pkg::ST_SEG : bms_pkg::ST_MREAD;
         end
         bms_pkg::ST_FETCH: begin
            state_in = bms_pkg::ST_OUT;
         end
         bms_pkg::ST_OUT: begin
            if (status.out_free) begin
               cmd.deliver = 1'b1;
               state_in    = bms_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = bms_pkg::ST_IDLE;
         end
      endcase
   end

   assign req_stall = (state_ff != bms_pkg::ST_IDLE);
   assign state     = state_ff;

endmodule

### hdl/bms_datapath.sv
module bms_datapath (
   input  logic                 clock,
   input  logic                 reset,
   input  bms_pkg::req_type     req_data,
   input  bms_pkg::cmd_type     cmd,
   input  logic                 rsp_stall,
   output bms_pkg::status_type  status,
   output logic                 rsp_valid,
   output bms_pkg::rsp_type     rsp_data
);

   localparam int CW = bms_pkg::CNT_W;
   localparam int AW = bms_pkg::ADDR_W;
   localparam int DW = bms_pkg::DATA_W;
   localparam int SW = bms_pkg::CNT_W + 2;

   // two stores used in turn as source and destination of a pass
   logic [DW-1:0] mem_a [bms_pkg::DEPTH];
   logic [DW-1:0] mem_b [bms_pkg::DEPTH];
   logic [DW-1:0] rd_a0_ff, rd_a1_ff, rd_b0_ff, rd_b1_ff;

   // control registers
   logic [CW-1:0] count_ff, count_in;
   logic [CW-1:0] rptr_ff, rptr_in;
   logic          sorted_ff, sorted_in;
   logic          src_ff, src_in;
   logic          rsp_valid_ff, rsp_valid_in;

   // merge registers
   logic [CW:0]   width_ff, width_in;
   logic [CW-1:0] lo_ff, lo_in;
   logic [CW-1:0] mid_ff, mid_in;
   logic [CW-1:0] hi_ff, hi_in;
   logic [CW-1:0] i_ff, i_in;
   logic [CW-1:0] j_ff, j_in;
   logic [CW-1:0] k_ff, k_in;
   bms_pkg::rsp_type rsp_ff, rsp_in;

   logic [SW-1:0] mid_sum, hi_sum, n_ext;
   logic [CW-1:0] mid_val, hi_val, k_next;
   logic [DW-1:0] left_v, right_v, pick_v;
   logic          take_left, seg_last, avail, out_free, load_wr;
   logic [AW-1:0] addr0, addr1, load_addr, wr_a_addr;
   logic [DW-1:0] wr_a_data;
   logic          wr_a_en, wr_b_en;

   // run bounds, clipped to the element count
   always_comb begin
      n_ext   = SW'(count_ff);
      mid_sum = SW'(lo_ff) + SW'(width_ff);
      hi_sum  = SW'(lo_ff) + (SW'(width_ff) << 1);
      mid_val = (mid_sum < n_ext) ? mid_sum[CW-1:0] : count_ff;
      hi_val  = (hi_sum < n_ext) ? hi_sum[CW-1:0] : count_ff;
   end

   // merge choice: left run wins on equal keys
   assign left_v    = src_ff ? rd_b0_ff : rd_a0_ff;
   assign right_v   = src_ff ? rd_b1_ff : rd_a1_ff;
   assign take_left = (i_ff < mid_ff) &&
                      ((j_ff >= hi_ff) || ($signed(left_v) <= $signed(right_v)));
   assign pick_v    = take_left ? left_v : right_v;
   assign k_next    = k_ff + 1'b1;
   assign seg_last  = (k_next == hi_ff);

   assign avail    = (rptr_ff < count_ff);
   assign out_free = !rsp_valid_ff || !rsp_stall;

   // memory port addressing
   assign addr0     = cmd.merge_addr ? i_ff[AW-1:0] : rptr_ff[AW-1:0];
   assign addr1     = j_ff[AW-1:0];
   assign load_addr = sorted_ff ? '0 : count_ff[AW-1:0];
   assign load_wr   = cmd.load && (sorted_ff || (count_ff < bms_pkg::DEPTH_CNT));
   assign wr_a_en   = load_wr || (cmd.merge_write && src_ff);
   assign wr_a_addr = cmd.merge_write ? k_ff[AW-1:0] : load_addr;
   assign wr_a_data = cmd.merge_write ? pick_v : DW'(req_data.value);
   assign wr_b_en   = cmd.merge_write && !src_ff;

   // store a
   always_ff @(posedge clock) begin
      if (wr_a_en) begin
         mem_a[wr_a_addr] <= wr_a_data;
      end
      rd_a0_ff <= mem_a[addr0];
      rd_a1_ff <= mem_a[addr1];
   end

   // store b
   always_ff @(posedge clock) begin
      if (wr_b_en) begin
         mem_b[k_ff[AW-1:0]] <= pick_v;
      end
      rd_b0_ff <= mem_b[addr0];
      rd_b1_ff <= mem_b[addr1];
   end

   // next values
   always_comb begin
      count_in     = count_ff;
      rptr_in      = rptr_ff;
      sorted_in    = sorted_ff;
      src_in       = src_ff;
      rsp_valid_in = rsp_valid_ff;
      width_in     = width_ff;
      lo_in        = lo_ff;
      mid_in       = mid_ff;
      hi_in        = hi_ff;
      i_in         = i_ff;
      j_in         = j_ff;
      k_in         = k_ff;
      rsp_in       = rsp_ff;

      // load, starting a new set after reading
      if (cmd.load) begin
         if (sorted_ff) begin
            count_in  = CW'(1);
            rptr_in   = '0;
            sorted_in = 1'b0;
            src_in    = 1'b0;
         end else if (count_ff < bms_pkg::DEPTH_CNT) begin
            count_in = count_ff + 1'b1;
         end
      end

      // pass sequencing
      if (cmd.sort_start) begin
         width_in = (CW+1)'(1);
         lo_in    = '0;
         src_in   = 1'b0;
      end
      if (cmd.pass_next) begin
         width_in = width_ff << 1;
         lo_in    = '0;
         src_in   = !src_ff;
      end
      if (cmd.sort_done) begin
         sorted_in = 1'b1;
         rptr_in   = '0;
      end

      // run pair setup and merge step
      if (cmd.seg_setup) begin
         mid_in = mid_val;
         hi_in  = hi_val;
         i_in   = lo_ff;
         j_in   = mid_val;
         k_in   = lo_ff;
      end
      if (cmd.merge_write) begin
         if (take_left) begin
            i_in = i_ff + 1'b1;
         end else begin
            j_in = j_ff + 1'b1;
         end
         k_in = k_next;
         if (seg_last) begin
            lo_in = hi_ff;
         end
      end

      // result register
      if (cmd.deliver) begin
         rsp_valid_in = 1'b1;
         if (avail) begin
            rsp_in.sorted_value = $signed(src_ff ? rd_b0_ff : rd_a0_ff);
            rsp_in.is_last      = ((rptr_ff + 1'b1) == count_ff);
            rsp_in.empty_res    = 1'b0;
            rptr_in             = rptr_ff + 1'b1;
         end else begin
            rsp_in.sorted_value = '0;
            rsp_in.is_last      = 1'b0;
            rsp_in.empty_res    = 1'b1;
         end
      end else if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         rptr_ff      <= '0;
         sorted_ff    <= 1'b0;
         src_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         rptr_ff      <= rptr_in;
         sorted_ff    <= sorted_in;
         src_ff       <= src_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      width_ff <= width_in;
      lo_ff    <= lo_in;
      mid_ff   <= mid_in;
      hi_ff    <= hi_in;
      i_ff     <= i_in;
      j_ff     <= j_in;
      k_ff     <= k_in;
      rsp_ff   <= rsp_in;
   end

   assign status.sorted    = sorted_ff;
   assign status.pass_more = (width_ff < (CW+1)'(count_ff));
   assign status.seg_more  = (lo_ff < count_ff);
   assign status.seg_last  = seg_last;
   assign status.out_free  = out_free;

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

### hdl/bottom_up_merge_sorter.sv
// Bottom-up merge sorter. Load words (func 0) are taken in one cycle each and
// give no result; loads past the store depth are dropped. The first read word
// (func 1) after a load sorts the set, then each read returns the next value
// in ascending signed order with is_last on the final one, or empty_res when
// nothing is left. While sorting, each merged element is first read from a
// store through its registered port and then compared and written into the
// other store, the two stores swapping roles every pass. A read of an already
// sorted set goes through a fetch state and an output state. The input stalls
// while sorting or while a read waits for the result register to drain;
// loads are still taken while an earlier result is waiting to be picked up.
module bottom_up_merge_sorter (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  bms_pkg::req_type  req_data,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output bms_pkg::rsp_type  rsp_data
);

   bms_pkg::cmd_type    cmd;
   bms_pkg::status_type status;
   bms_pkg::state_type  state;

   // sequencer
   bms_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_func  (req_data.func),
      .status    (status),
      .req_stall (req_stall),
      .cmd       (cmd),
      .state     (state)
   );

   // stores, counters and result register
   bms_datapath u_datapath (
      .clock     (clock),
      .reset     (reset),
      .req_data  (req_data),
      .cmd       (cmd),
      .rsp_stall (rsp_stall),
      .status    (status),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data)
   );

`ifndef SYNTHESIS
   // at most one datapath action per cycle
   a_single_action: assert property (@(posedge clock) disable iff (reset)
      $onehot0({cmd.load, cmd.sort_start, cmd.pass_next, cmd.sort_done,
                cmd.seg_setup, cmd.merge_write, cmd.deliver}))
      else $error("more than one datapath action at once");

   // a result is only loaded when the register can take it
   a_deliver_free: assert property (@(posedge clock) disable iff (reset)
      cmd.deliver |-> status.out_free)
      else $error("result register overwritten");

   // a delivered result shows up next cycle
   a_deliver_valid: assert property (@(posedge clock) disable iff (reset)
      cmd.deliver |=> rsp_valid)
      else $error("delivered result not presented");

   // an accepted read blocks further input until answered
   a_read_stalls: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall && req_data.func == bms_pkg::FUNC_READ)
      |=> (req_stall && state != bms_pkg::ST_IDLE))
      else $error("read word did not start processing");
`endif

endmodule

### sim/tb_top.sv
// expected-word checker: keeps its own copy of the loaded set and predicts reads
class sort_checker;
   logic signed [bms_pkg::DATA_W-1:0] set_values[$];
   int unsigned                       next_index;
   bit                                set_sorted;
   bms_pkg::rsp_type                  due_sorted_words[$];
   int                                errors;

   function new();
      next_index = 0;
      set_sorted = 1'b0;
      errors     = 0;
   endfunction

   // bottom-up merge of runs 1, 2, 4 ... wide, left run wins on equal keys
   function void merge_sort_set();
      int n;
      int width;
      int lo;
      int mid;
      int hi;
      int i;
      int j;
      int k;
      logic signed [bms_pkg::DATA_W-1:0] scratch[];
      n = set_values.size();
      scratch = new[n];
      for (width = 1; width < n; width = width * 2) begin
         for (lo = 0; lo < n; lo = lo + 2 * width) begin
            mid = (lo + width < n) ? lo + width : n;
            hi  = (lo + 2 * width < n) ? lo + 2 * width : n;
            i = lo;
            j = mid;
            for (k = lo; k < hi; k++) begin
               if (j >= hi || (i < mid && set_values[i] <= set_values[j])) begin
                  scratch[k] = set_values[i];
                  i = i + 1;
               end else begin
                  scratch[k] = set_values[j];
                  j = j + 1;
               end
            end
            for (k = lo; k < hi; k++)
               set_values[k] = scratch[k];
         end
      end
   endfunction

   // accepted input word: load into the set or predict the next sorted word
   function void note_request(bms_pkg::req_type w);
      bms_pkg::rsp_type due;
      if (w.func == bms_pkg::FUNC_LOAD) begin
         // a load once reading has begun opens a new set
         if (set_sorted) begin
            set_values.delete();
            next_index = 0;
            set_sorted = 1'b0;
         end
         // loads into a full store are dropped
         if (set_values.size() < bms_pkg::DEPTH)
            set_values.push_back(w.value);
      end else begin
         if (!set_sorted) begin
            merge_sort_set();
            set_sorted = 1'b1;
            next_index = 0;
         end
         if (next_index < set_values.size()) begin
            due.sorted_value = set_values[next_index];
            due.is_last      = (next_index + 1 == set_values.size());
            due.empty_res    = 1'b0;
            next_index       = next_index + 1;
         end else begin
            due.sorted_value = '0;
            due.is_last      = 1'b0;
            due.empty_res    = 1'b1;
         end
         due_sorted_words.push_back(due);
      end
   endfunction

   // accepted result word against the oldest prediction
   function void check_word(bms_pkg::rsp_type r);
      bms_pkg::rsp_type due;
      if (due_sorted_words.size() == 0) begin
         $error("result word with nothing due: sorted_value %0d is_last %0b empty_res %0b",
                r.sorted_value, r.is_last, r.empty_res);
         errors++;
      end else begin
         due = due_sorted_words.pop_front();
         if (r.sorted_value !== due.sorted_value) begin
            $error("sorted_value: expected %0d, actual %0d", due.sorted_value, r.sorted_value);
            errors++;
         end
         if (r.is_last !== due.is_last) begin
            $error("is_last: expected %0b, actual %0b", due.is_last, r.is_last);
            errors++;
         end
         if (r.empty_res !== due.empty_res) begin
            $error("empty_res: expected %0b, actual %0b", due.empty_res, r.empty_res);
            errors++;
         end
      end
   endfunction
endclass

module tb_top;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int CYCLE_LIMIT  = 1000000;
   localparam int RANDOM_ITEMS = 850;
   localparam int DRAIN_CYCLES = 64;

   logic             clock     = 1'b0;
   logic             reset     = 1'b1;
   logic             req_valid = 1'b0;
   logic             req_stall;
   bms_pkg::req_type req_data  = '0;
   logic             rsp_valid;
   logic             rsp_stall = 1'b0;
   bms_pkg::rsp_type rsp_data;

   sort_checker board      = new();
   bit          idle_free  = 1'b0;
   int          cycles     = 0;
   int          sent_items = 0;

   bottom_up_merge_sorter dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   // clock
   initial begin
      forever #5 clock = ~clock;
   end

   // watchdog
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles >= CYCLE_LIMIT) begin
         $display("[FAIL] regression broken");
         $finish;
      end
   end

   // accepted words on both channels
   always @(posedge clock) begin
      if (!reset && req_valid && !req_stall)
         board.note_request(req_data);
      if (!reset && rsp_valid && !rsp_stall)
         board.check_word(rsp_data);
   end

   // idle cycles per word, none during a burst stretch
   function automatic int draw_gap();
      return idle_free ? 0 : $urandom_range(0, 19);
   endfunction

   // present one word and hold it until taken
   task automatic send_word(input logic func, input logic [bms_pkg::DATA_W-1:0] value);
      int gap;
      gap = draw_gap();
      if ($urandom_range(0, 49) == 0)
         idle_free = ~idle_free;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid     <= 1'b1;
      req_data.func  <= func;
      req_data.value <= value;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      sent_items++;
   endtask

   task automatic load_word(input logic [bms_pkg::DATA_W-1:0] value);
      send_word(bms_pkg::FUNC_LOAD, value);
   endtask

   task automatic read_word();
      send_word(bms_pkg::FUNC_READ, $urandom());
   endtask

   // value styles: full range, narrow band with many ties, extremes
   function automatic logic [bms_pkg::DATA_W-1:0] draw_value(input int style);
      logic [bms_pkg::DATA_W-1:0] corner[6];
      corner = '{32'h8000_0000, 32'h7fff_ffff, 32'h0000_0000,
                 32'hffff_ffff, 32'h8000_0001, 32'h7fff_fffe};
      case (style)
         0:       return $urandom();
         1:       return $urandom_range(0, 8) - 32'd4;
         default: return corner[$urandom_range(0, 5)];
      endcase
   endfunction

   // receiver stall per word
   initial begin
      int gap;
      forever begin
         gap = draw_gap();
         if (gap > 0) begin
            rsp_stall <= 1'b1;
            repeat (gap) @(posedge clock);
         end
         rsp_stall <= 1'b0;
         @(posedge clock);
         while (!rsp_valid) @(posedge clock);
      end
   end

   // stimulus
   initial begin
      int set_size;
      int reads;
      int style;
      int pick;
      int k;
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // read of an empty set straight after reset
      read_word();

      // extremes, ties and an extra read past the end
      load_word(32'h8000_0000);
      load_word(32'h7fff_ffff);
      load_word(32'h0000_0000);
      load_word(32'hffff_ffff);
      load_word(32'h0000_0001);
      load_word(32'h7fff_ffff);
      load_word(32'h8000_0000);
      load_word(32'h0000_0005);
      load_word(32'h0000_0005);
      repeat (10) read_word();

      // load after reading starts a new set, then read it dry twice
      load_word(32'h0000_0003);
      read_word();
      read_word();
      read_word();

      // fill the store past its depth, read a few, abandon the set
      for (k = 0; k < bms_pkg::DEPTH + 3; k++)
         load_word(draw_value(k % 3));
      repeat (6) read_word();

      // random sets: mostly well-formed load runs then reads
      sent_items = 0;
      while (sent_items < RANDOM_ITEMS) begin
         pick = $urandom_range(0, 99);
         if (pick < 10) begin
            // noise: loads and reads mixed
            repeat ($urandom_range(1, 10)) begin
               if ($urandom_range(0, 1))
                  read_word();
               else
                  load_word(draw_value($urandom_range(0, 2)));
            end
         end else begin
            if (pick < 85)
               set_size = $urandom_range(0, 24);
            else if (pick < 97)
               set_size = $urandom_range(25, 100);
            else
               set_size = $urandom_range(101, 300);
            style = $urandom_range(0, 2);
            for (k = 0; k < set_size; k++)
               load_word(draw_value(style));
            if ($urandom_range(0, 4) == 0)
               reads = $urandom_range(0, set_size);
            else
               reads = set_size + $urandom_range(0, 2);
            repeat (reads) read_word();
         end
      end
      req_valid <= 1'b0;

      // let the last accepted word reach the checker
      @(posedge clock);

      // drain outstanding results, then watch for strays
      while (board.due_sorted_words.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (board.errors == 0 && board.due_sorted_words.size() == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

endmodule

### filelist.f
hdl/bms_pkg.sv
hdl/bms_ctrl.sv
hdl/bms_datapath.sv
hdl/bottom_up_merge_sorter.sv
sim/tb_top.sv
